/* design/erp_pkg.sv */
`default_nettype none
package erp_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DIV_STEPS = 16;
  localparam logic [31:0] ONE_Q16  = 32'h0001_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_X       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Y       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Z       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_X      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Y      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Z      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALAR_LOW  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALAR_HIGH = 4'd7;

  typedef enum logic [1:0] {
    FRAC_ZERO,
    FRAC_ONE,
    FRAC_DIV
  } frac_sel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] elevation;
    logic               degenerate_axis;
  } out_item_t;

endpackage
`default_nettype wire

/* design/elevation_ramp_projector_unit.sv */
// Each item passes stages 1 to 3, the divider input register, the divider stages,
// the scale stage and the output register, whose valid bit drives out_valid.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The fraction comes from a 16-stage restoring divider, one quotient bit per stage.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module elevation_ramp_projector_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire  erp_pkg::in_item_t             in_item,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [erp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [31:0]                         cfg_data,
  output logic                                out_valid,
  output erp_pkg::out_item_t                  out_item
);
  import erp_pkg::*;

  // configuration registers
  logic signed [31:0] low_x_r, low_y_r, low_z_r, high_x_r, high_y_r, high_z_r;
  logic signed [31:0] scalar_low_r, scalar_high_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_x_r       <= '0;
      low_y_r       <= '0;
      low_z_r       <= '0;
      high_x_r      <= '0;
      high_y_r      <= '0;
      high_z_r      <= signed'(ONE_Q16);
      scalar_low_r  <= '0;
      scalar_high_r <= signed'(ONE_Q16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOW_X:       low_x_r       <= signed'(cfg_data);
        REG_LOW_Y:       low_y_r       <= signed'(cfg_data);
        REG_LOW_Z:       low_z_r       <= signed'(cfg_data);
        REG_HIGH_X:      high_x_r      <= signed'(cfg_data);
        REG_HIGH_Y:      high_y_r      <= signed'(cfg_data);
        REG_HIGH_Z:      high_z_r      <= signed'(cfg_data);
        REG_SCALAR_LOW:  scalar_low_r  <= signed'(cfg_data);
        REG_SCALAR_HIGH: scalar_high_r <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  logic in_fire;
  assign in_fire = start && !busy;

  // stage 1: offsets from the low point
  logic              s1_vld_r;
  logic signed [32:0] s1_v_r [3];
  logic signed [32:0] s1_d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= in_fire;
    s1_v_r[0] <= 33'(in_item.point_x) - 33'(low_x_r);
    s1_v_r[1] <= 33'(in_item.point_y) - 33'(low_y_r);
    s1_v_r[2] <= 33'(in_item.point_z) - 33'(low_z_r);
    s1_d_r[0] <= 33'(high_x_r) - 33'(low_x_r);
    s1_d_r[1] <= 33'(high_y_r) - 33'(low_y_r);
    s1_d_r[2] <= 33'(high_z_r) - 33'(low_z_r);
  end

  // stage 2: products
  logic              s2_vld_r;
  logic signed [65:0] s2_vd_r [3];
  logic signed [65:0] s2_dd_r [3];
  logic signed [32:0] s2_vz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    for (int k = 0; k < 3; k++) begin
      s2_vd_r[k] <= s1_v_r[k] * s1_d_r[k];
      s2_dd_r[k] <= s1_d_r[k] * s1_d_r[k];
    end
    s2_vz_r <= s1_v_r[2];
  end

  // stage 3: dot products
  logic              s3_vld_r;
  logic signed [69:0] s3_num_r;
  logic [67:0]        s3_den_r;
  logic signed [32:0] s3_vz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
    s3_num_r <= 70'(s2_vd_r[0]) + 70'(s2_vd_r[1]) + 70'(s2_vd_r[2]);
    s3_den_r <= 68'(s2_dd_r[0][65:0]) + 68'(s2_dd_r[1][65:0]) + 68'(s2_dd_r[2][65:0]);
    s3_vz_r  <= s2_vz_r;
  end

  // stage 4: fallback axis and clamp decision
  logic              degen;
  logic signed [69:0] num_use;
  logic [67:0]        den_use;
  frac_sel_t          sel;

  always_comb begin
    degen   = (s3_den_r == '0);
    num_use = degen ? {{21{s3_vz_r[32]}}, s3_vz_r, 16'b0} : s3_num_r;
    den_use = degen ? 68'h1_0000_0000 : s3_den_r;
    if (num_use <= 0)                   sel = FRAC_ZERO;
    else if (num_use >= $signed({2'b0, den_use})) sel = FRAC_ONE;
    else                                sel = FRAC_DIV;
  end

  // divider pipeline, index 0 is stage 4
  logic        dv_vld_r [DIV_STEPS+1];
  logic [67:0] dv_rem_r [DIV_STEPS+1];
  logic [67:0] dv_den_r [DIV_STEPS+1];
  logic [15:0] dv_q_r   [DIV_STEPS+1];
  frac_sel_t   dv_sel_r [DIV_STEPS+1];
  logic        dv_deg_r [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else        dv_vld_r[0] <= s3_vld_r;
    dv_rem_r[0] <= num_use[67:0];
    dv_den_r[0] <= den_use;
    dv_q_r[0]   <= '0;
    dv_sel_r[0] <= sel;
    dv_deg_r[0] <= degen;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic [68:0] shifted;
    logic [68:0] diff;
    logic        take;
    always_comb begin
      shifted = {dv_rem_r[g], 1'b0};
      diff    = shifted - {1'b0, dv_den_r[g]};
      take    = (shifted >= {1'b0, dv_den_r[g]});
    end
    // advance one quotient bit
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[g+1] <= 1'b0;
      else        dv_vld_r[g+1] <= dv_vld_r[g];
      dv_rem_r[g+1] <= take ? diff[67:0] : shifted[67:0];
      dv_den_r[g+1] <= dv_den_r[g];
      dv_q_r[g+1]   <= {dv_q_r[g][14:0], take};
      dv_sel_r[g+1] <= dv_sel_r[g];
      dv_deg_r[g+1] <= dv_deg_r[g];
    end
  end

  // scale stage: fraction times scalar span
  logic [16:0]        frac;
  logic signed [32:0] span;
  logic              mu_vld_r;
  logic signed [50:0] mu_t_r;
  logic              mu_deg_r;

  always_comb begin
    case (dv_sel_r[DIV_STEPS])
      FRAC_ZERO: frac = '0;
      FRAC_ONE:  frac = 17'(ONE_Q16);
      default:   frac = {1'b0, dv_q_r[DIV_STEPS]};
    endcase
    span = 33'(scalar_high_r) - 33'(scalar_low_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mu_vld_r <= 1'b0;
    else        mu_vld_r <= dv_vld_r[DIV_STEPS];
    mu_t_r   <= $signed({1'b0, frac}) * span;
    mu_deg_r <= dv_deg_r[DIV_STEPS];
  end

  // output stage: floor shift and offset
  logic out_vld_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= mu_vld_r;
    out_r.elevation       <= scalar_low_r + signed'(mu_t_r[47:16]);
    out_r.degenerate_axis <= mu_deg_r;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  a_degen_den: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[0] && dv_deg_r[0]) |-> (dv_den_r[0] == 68'h1_0000_0000))
    else $error("fallback axis length wrong");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[DIV_STEPS] && dv_sel_r[DIV_STEPS] == FRAC_DIV) |->
      (dv_rem_r[DIV_STEPS] < dv_den_r[DIV_STEPS]))
    else $error("divider remainder out of range");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[0] && dv_sel_r[0] == FRAC_DIV) |-> (dv_rem_r[0] < dv_den_r[0]))
    else $error("divider entered with numerator above denominator");
  a_out_follow: assert property (@(posedge clk) disable iff (!rst_n)
    mu_vld_r |=> out_valid)
    else $error("result strobe lost");

endmodule
`default_nettype wire
